// ===== src/mssf_pkg.sv =====
// ----------------------------------------------------------------------------
// mssf_pkg
// Shared widths, reciprocal constant and segment decoder for the
// seven-segment frame generator.
// ----------------------------------------------------------------------------
package mssf_pkg;

    localparam int VALUE_W    = 32;
    localparam int BCD_W      = 4;
    localparam int SEG_W      = 7;
    localparam int EN_W       = 4;
    localparam int OUT_DATA_W = 16;
    localparam int QUEUE_DEPTH = 2;

    // ceil(2^35 / 10), exact quotient for every 32-bit dividend after >> 35
    localparam logic [VALUE_W-1:0] RECIP_TEN = 32'hCCCC_CCCD;
    localparam int RECIP_SHIFT = 35;

    localparam logic [SEG_W-1:0] SEG_0 = 7'h3F;
    localparam logic [SEG_W-1:0] SEG_1 = 7'h06;
    localparam logic [SEG_W-1:0] SEG_2 = 7'h5B;
    localparam logic [SEG_W-1:0] SEG_3 = 7'h4F;
    localparam logic [SEG_W-1:0] SEG_4 = 7'h66;
    localparam logic [SEG_W-1:0] SEG_5 = 7'h6D;
    localparam logic [SEG_W-1:0] SEG_6 = 7'h7D;
    localparam logic [SEG_W-1:0] SEG_7 = 7'h07;
    localparam logic [SEG_W-1:0] SEG_8 = 7'h7F;
    localparam logic [SEG_W-1:0] SEG_9 = 7'h6F;

    typedef logic [BCD_W-1:0] bcd_t;
    typedef logic [SEG_W-1:0] seg_t;
    typedef logic [EN_W-1:0]  en_t;

    function automatic seg_t seg_decode(input bcd_t d);
        seg_t s;
        unique case (d)
            4'd0:    s = SEG_0;
            4'd1:    s = SEG_1;
            4'd2:    s = SEG_2;
            4'd3:    s = SEG_3;
            4'd4:    s = SEG_4;
            4'd5:    s = SEG_5;
            4'd6:    s = SEG_6;
            4'd7:    s = SEG_7;
            4'd8:    s = SEG_8;
            4'd9:    s = SEG_9;
            default: s = SEG_0;
        endcase
        return s;
    endfunction

endpackage

// ===== src/multiplexed_seven_segment_frames.sv =====
// ----------------------------------------------------------------------------
// multiplexed_seven_segment_frames
// Turns a 32-bit binary value into the frames of a multiplexed
// seven-segment display.
// ----------------------------------------------------------------------------
// Each accepted value gives DIGITS + 1 output transactions: one per display,
// most significant digit first, with its active-low enable, then a blank
// frame with all enables high, the units pattern and tlast set. Only the low
// DIGITS decimal digits are shown. The frame emitter sends one frame per
// cycle while the receiver is ready; the divider ahead of it peels off one
// digit at a time, one divide by ten each, and a two-entry queue lets it
// run ahead of the output.
module multiplexed_seven_segment_frames
    import mssf_pkg::*;
#(
    parameter int DIGITS = 4
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [VALUE_W-1:0]    s_axis_tdata,   // [31:0] value
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [6:0] segments, [10:7] digit_enables
    output logic                  m_axis_tlast
);

    localparam int ENTRY_W = DIGITS * BCD_W;
    localparam int PAD_W   = OUT_DATA_W - SEG_W - EN_W;

    logic               push_valid;
    logic               push_ready;
    logic [ENTRY_W-1:0] push_data;
    logic               q_valid;
    logic               q_pop;
    logic [ENTRY_W-1:0] q_data;
    seg_t               segments;
    en_t                digit_enables;

    mssf_front #(
        .DIGITS (DIGITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_value   (s_axis_tdata),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    mssf_queue #(
        .WIDTH (ENTRY_W)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (push_valid),
        .wr_ready (push_ready),
        .wr_data  (push_data),
        .rd_valid (q_valid),
        .rd_pop   (q_pop),
        .rd_data  (q_data)
    );

    mssf_back #(
        .DIGITS (DIGITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_pop        (q_pop),
        .q_data       (q_data),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_segments (segments),
        .out_enables  (digit_enables),
        .out_last     (m_axis_tlast)
    );

    assign m_axis_tdata = {{PAD_W{1'b0}}, digit_enables, segments};

endmodule

// ===== src/mssf_front.sv =====
// ----------------------------------------------------------------------------
// mssf_front
// Accepts values and peels off one decimal digit per cycle, holding the last
// until the queue has room, then pushes the digit set into the queue.
// ----------------------------------------------------------------------------
module mssf_front
    import mssf_pkg::*;
#(
    parameter int DIGITS = 4
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [VALUE_W-1:0]       in_value,
    output logic                     push_valid,
    input  logic                     push_ready,
    output logic [DIGITS*BCD_W-1:0]  push_data
);

    localparam int CW = (DIGITS > 1) ? $clog2(DIGITS) : 1;
    localparam logic [CW-1:0] LAST_CNT = CW'(DIGITS - 1);

    logic [VALUE_W-1:0]   v_reg;
    logic [CW-1:0]        cnt_reg;
    logic                 busy_reg;
    bcd_t                 dig_reg [DIGITS];

    logic [2*VALUE_W-1:0] prod;
    logic [VALUE_W-1:0]   quot;
    logic [VALUE_W-1:0]   ten_quot;
    bcd_t                 rem;
    logic                 last_step;
    logic                 step;
    logic                 accept;

    always_comb
    begin
        prod      = (2*VALUE_W)'(v_reg) * (2*VALUE_W)'(RECIP_TEN);
        quot      = VALUE_W'(prod >> RECIP_SHIFT);
        ten_quot  = (quot << 3) + (quot << 1);
        rem       = BCD_W'(v_reg - ten_quot);
        last_step = (cnt_reg == LAST_CNT);
        push_valid = busy_reg && last_step;
        step      = busy_reg && !(last_step && !push_ready);
        in_ready  = !busy_reg || (push_valid && push_ready);
        accept    = in_valid && in_ready;
    end

    // the last digit goes straight from the divider into the entry
    always_comb
    begin
        for (int i = 0; i < DIGITS; i++)
        begin
            if (i == DIGITS - 1)
                push_data[i*BCD_W +: BCD_W] = rem;
            else
                push_data[i*BCD_W +: BCD_W] = dig_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (accept)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (step)
            begin
                if (last_step)
                    busy_reg <= 1'b0;
                else
                    cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            v_reg <= in_value;
        else if (step)
            v_reg <= quot;
        if (step)
            dig_reg[cnt_reg] <= rem;
    end

endmodule

// ===== src/mssf_queue.sv =====
// ----------------------------------------------------------------------------
// mssf_queue
// Two-entry queue of digit sets between the divider and the frame emitter.
// ----------------------------------------------------------------------------
module mssf_queue
    import mssf_pkg::*;
#(
    parameter int WIDTH = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_valid,
    output logic             wr_ready,
    input  logic [WIDTH-1:0] wr_data,
    output logic             rd_valid,
    input  logic             rd_pop,
    output logic [WIDTH-1:0] rd_data
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int NW = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] mem [QUEUE_DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [NW-1:0]    count_reg;
    logic             do_push;
    logic             do_pop;

    always_comb
    begin
        wr_ready = (count_reg != NW'(QUEUE_DEPTH));
        rd_valid = (count_reg != '0);
        rd_data  = mem[rd_ptr_reg];
        do_push  = wr_valid && wr_ready;
        do_pop   = rd_pop && rd_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= wr_data;
    end

endmodule

// ===== src/mssf_back.sv =====
// ----------------------------------------------------------------------------
// mssf_back
// Walks one digit set through its display frames, one frame per cycle when
// the output is not stalled, into a registered output stage.
// ----------------------------------------------------------------------------
module mssf_back
    import mssf_pkg::*;
#(
    parameter int DIGITS = 4
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     q_valid,
    output logic                     q_pop,
    input  logic [DIGITS*BCD_W-1:0]  q_data,
    output logic                     out_valid,
    input  logic                     out_ready,
    output seg_t                     out_segments,
    output en_t                      out_enables,
    output logic                     out_last
);

    localparam int FW = $clog2(DIGITS + 1);
    localparam logic [FW-1:0] BLANK_FRAME = FW'(DIGITS);

    logic [FW-1:0] frame_reg;
    logic          valid_reg;
    seg_t          seg_reg;
    en_t           en_reg;
    logic          last_reg;

    logic          load;
    logic          blank;
    bcd_t          digit;
    en_t           en;

    always_comb
    begin
        load  = q_valid && (!valid_reg || out_ready);
        blank = (frame_reg == BLANK_FRAME);
        q_pop = load && blank;
        // units digit by default, which also serves the blank frame
        digit = q_data[BCD_W-1:0];
        for (int i = 0; i < DIGITS; i++)
        begin
            if (int'(frame_reg) == DIGITS - 1 - i)
                digit = q_data[i*BCD_W +: BCD_W];
        end
        for (int j = 0; j < EN_W; j++)
            en[j] = (int'(frame_reg) != j);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                valid_reg <= 1'b1;
                if (blank)
                    frame_reg <= '0;
                else
                    frame_reg <= frame_reg + 1'b1;
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            seg_reg  <= seg_decode(digit);
            en_reg   <= en;
            last_reg <= blank;
        end
    end

    assign out_valid    = valid_reg;
    assign out_segments = seg_reg;
    assign out_enables  = en_reg;
    assign out_last     = last_reg;

    a_last_all_off : assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && last_reg) |-> (en_reg == '1))
        else $error("blank frame with a digit enabled");

    a_frame_range : assert property (@(posedge clk) disable iff (!rst_n)
        frame_reg <= BLANK_FRAME)
        else $error("frame counter out of range");

    a_mid_set_held : assert property (@(posedge clk) disable iff (!rst_n)
        (frame_reg != '0) |-> q_valid)
        else $error("digit set left the queue before its last frame");

    a_pop_after_blank : assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> (valid_reg && last_reg))
        else $error("digit set popped without a blank frame");

endmodule

// ===== sim/multiplexed_seven_segment_frames_test.sv =====
// ----------------------------------------------------------------------------
// multiplexed_seven_segment_frames_test
// Self-checking bench for the seven-segment frame generator: a directed table
// of values (digit extremes, values above four digits, full-range words) and
// then random bursts. A local predictor turns every value accepted on the
// input stream into five expected frames; each frame leaving the block is
// compared field by field with the oldest of them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module multiplexed_seven_segment_frames_test;

    import mssf_pkg::*;

    localparam int SHOWN_DIGITS = 4;
    localparam int GLYPHS_W     = SHOWN_DIGITS * SEG_W;
    localparam int RESET_CYCLES = 11;
    localparam int RANDOM_ITEMS = 140;
    localparam int DIRECTED_N   = 21;
    localparam int HOLD_OFF_AT  = 60;
    localparam int HOLD_OFF_LEN = 80;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 100000;

    localparam seg_t DIGIT_GLYPH [10] = '{
        7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
    };

    typedef struct packed {
        seg_t segments;
        en_t  enables;
        logic last;
    } frame_t;

    // glyphs: most significant digit in the top bits, units in the low bits
    typedef struct packed {
        logic [VALUE_W-1:0]  value;
        logic                typed;
        logic [GLYPHS_W-1:0] glyphs;
    } display_row_t;

    localparam display_row_t DIRECTED_ROWS [DIRECTED_N] = '{
        '{32'd0,          1'b1, {7'h3F, 7'h3F, 7'h3F, 7'h3F}},
        '{32'd9999,       1'b1, {7'h6F, 7'h6F, 7'h6F, 7'h6F}},
        '{32'd10000,      1'b1, {7'h3F, 7'h3F, 7'h3F, 7'h3F}},
        '{32'hFFFF_FFFF,  1'b1, {7'h07, 7'h5B, 7'h6F, 7'h6D}},
        '{32'd8888,       1'b1, {7'h7F, 7'h7F, 7'h7F, 7'h7F}},
        '{32'd1234,       1'b1, {7'h06, 7'h5B, 7'h4F, 7'h66}},
        '{32'd5678,       1'b1, {7'h6D, 7'h7D, 7'h07, 7'h7F}},
        '{32'd9,          1'b0, '0},
        '{32'd90,         1'b0, '0},
        '{32'd900,        1'b0, '0},
        '{32'd9000,       1'b0, '0},
        '{32'd19999,      1'b0, '0},
        '{32'd12345678,   1'b0, '0},
        '{32'h8000_0000,  1'b0, '0},
        '{32'hAAAA_AAAA,  1'b0, '0},
        '{32'h5555_5555,  1'b0, '0},
        '{32'hFFFF_FFFE,  1'b0, '0},
        '{32'd4294960000, 1'b0, '0},
        '{32'd1,          1'b0, '0},
        '{32'd10,         1'b0, '0},
        '{32'd4321,       1'b0, '0}
    };

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [VALUE_W-1:0]    s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;

    // side information travelling with the value on offer
    logic                offer_typed = 1'b0;
    logic [GLYPHS_W-1:0] offer_glyphs = '0;

    logic   hold_off = 1'b0;
    int     cycle_count = 0;
    int     values_accepted = 0;
    int     error_count = 0;
    frame_t frames_expected [$];

    multiplexed_seven_segment_frames #(
        .DIGITS (SHOWN_DIGITS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 clk = ~clk;

    function automatic logic [GLYPHS_W-1:0] glyphs_of(input logic [VALUE_W-1:0] value);
        logic [VALUE_W-1:0]  rest;
        logic [GLYPHS_W-1:0] glyphs;
        rest   = value;
        glyphs = '0;
        for (int i = 0; i < SHOWN_DIGITS; i++)
        begin
            glyphs[i*SEG_W +: SEG_W] = DIGIT_GLYPH[rest % 10];
            rest = rest / 10;
        end
        return glyphs;
    endfunction

    function automatic void queue_frames(input logic [GLYPHS_W-1:0] glyphs);
        frame_t f;
        for (int k = 0; k < SHOWN_DIGITS; k++)
        begin
            f.segments = glyphs[(SHOWN_DIGITS-1-k)*SEG_W +: SEG_W];
            f.enables  = (k < EN_W) ? en_t'(~(en_t'(1) << k)) : '1;
            f.last     = 1'b0;
            frames_expected.push_back(f);
        end
        // blank frame keeps the units pattern on the segment lines
        f.segments = glyphs[SEG_W-1:0];
        f.enables  = '1;
        f.last     = 1'b1;
        frames_expected.push_back(f);
    endfunction

    function automatic logic [VALUE_W-1:0] random_value();
        logic [VALUE_W-1:0] v;
        case ($urandom_range(0, 9))
            5, 6:    v = $urandom_range(0, 9999);
            7:       v = $urandom_range(1, 429496) * 10000 + $urandom_range(0, 9)
                         + ($urandom_range(0, 1) ? 9990 : 0);
            8:       v = 32'hFFFF_0000 | $urandom_range(0, 16'hFFFF);
            9:       v = $urandom_range(0, 9) * 1000 + $urandom_range(0, 9);
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task automatic offer_value(input logic [VALUE_W-1:0] value, input logic typed,
                               input logic [GLYPHS_W-1:0] glyphs);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        offer_typed   <= typed;
        offer_glyphs  <= glyphs;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("multiplexed_seven_segment_frames_test failed");
            $finish;
        end
    end

    // both streams are watched here, so expectations and checks never race
    always @(posedge clk)
    begin
        frame_t want;
        if (m_axis_tvalid && m_axis_tready)
        begin
            if (frames_expected.size() == 0)
            begin
                error_count++;
                $display("%0t: frame with none expected: tdata %h tlast %b",
                         $time, m_axis_tdata, m_axis_tlast);
            end
            else
            begin
                want = frames_expected.pop_front();
                if (m_axis_tdata[SEG_W-1:0] !== want.segments)
                begin
                    error_count++;
                    $display("%0t: segments expected %h actual %h",
                             $time, want.segments, m_axis_tdata[SEG_W-1:0]);
                end
                if (m_axis_tdata[SEG_W +: EN_W] !== want.enables)
                begin
                    error_count++;
                    $display("%0t: digit enables expected %h actual %h",
                             $time, want.enables, m_axis_tdata[SEG_W +: EN_W]);
                end
                if (m_axis_tlast !== want.last)
                begin
                    error_count++;
                    $display("%0t: tlast expected %b actual %b",
                             $time, want.last, m_axis_tlast);
                end
                if (m_axis_tdata[OUT_DATA_W-1:SEG_W+EN_W] !== '0)
                begin
                    error_count++;
                    $display("%0t: tdata padding expected 0 actual %h",
                             $time, m_axis_tdata[OUT_DATA_W-1:SEG_W+EN_W]);
                end
            end
        end

        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            values_accepted++;
            queue_frames(offer_typed ? offer_glyphs : glyphs_of(s_axis_tdata));
        end

        // receiver pattern follows two bits of the cycle count, unless held off
        if (hold_off)
            m_axis_tready <= 1'b0;
        else
        begin
            case (cycle_count[8:7])
                2'd0:    m_axis_tready <= 1'b1;
                2'd1:    m_axis_tready <= ($urandom_range(0, 3) != 0);
                2'd2:    m_axis_tready <= ($urandom_range(0, 3) == 0);
                default: m_axis_tready <= (cycle_count[1:0] != 2'b11);
            endcase
        end
    end

    // one long receiver stall while the sender keeps offering
    initial
    begin
        wait (values_accepted >= HOLD_OFF_AT);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_OFF_LEN) @(posedge clk);
        hold_off <= 1'b0;
    end

    initial
    begin
        int items_left;
        int burst;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED_ROWS[i])
        begin
            offer_value(DIRECTED_ROWS[i].value, DIRECTED_ROWS[i].typed,
                        DIRECTED_ROWS[i].glyphs);
            if ($urandom_range(0, 2) == 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
            end
        end

        // sender pauses until the block has drained
        s_axis_tvalid <= 1'b0;
        // let the last transaction reach the expected list before waiting
        @(posedge clk);
        wait (frames_expected.size() == 0);
        @(posedge clk);

        items_left = RANDOM_ITEMS;
        while (items_left > 0)
        begin
            burst = $urandom_range(1, 12);
            while (burst > 0 && items_left > 0)
            begin
                offer_value(random_value(), 1'b0, '0);
                burst--;
                items_left--;
            end
            if ($urandom_range(0, 3) != 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
        s_axis_tvalid <= 1'b0;
        @(posedge clk);

        wait (frames_expected.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("multiplexed_seven_segment_frames_test passed");
        else
            $display("multiplexed_seven_segment_frames_test failed");
        $finish;
    end

endmodule

// ===== files.f =====
src/mssf_pkg.sv
src/mssf_front.sv
src/mssf_queue.sv
src/mssf_back.sv
src/multiplexed_seven_segment_frames.sv
sim/multiplexed_seven_segment_frames_test.sv
